// ===== src/pcn_pkg.sv =====
`default_nettype none
package pcn_pkg;
   localparam int MAX_CHANNELS = 4;
   localparam int MAX_DIM = 4096;
   localparam int CH_W = 2;
   localparam int DIM_W = 13;
   localparam int POS_W = 24;
   localparam int X_W = 16;
   localparam int D_W = 17;
   localparam int MAG_W = 30;
   localparam int Q_W = 31;
   localparam int RES_W = 24;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW = 2;

   localparam logic [2:0] REG_LAYOUT = 3'd0;
   localparam logic [2:0] REG_COUNT = 3'd1;
   localparam logic [2:0] REG_HEIGHT = 3'd2;
   localparam logic [2:0] REG_WIDTH = 3'd3;
   localparam logic [2:0] REG_MEAN = 3'd4;
   localparam logic [2:0] REG_DEV = 3'd5;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_ZERO_DEV = 2'd1;
   localparam logic [1:0] ST_SAT = 2'd2;

   typedef struct packed {
      logic [CH_W-1:0] channel;
      logic zero_dev;
      logic neg;
      logic [MAG_W-1:0] dividend;
      logic [16:0] divisor;
   } work_type;
endpackage
`default_nettype wire

// ===== src/pcn_front.sv =====
`default_nettype none
module pcn_front (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic take,
   input  wire logic signed [15:0] sample,
   input  wire logic cfg_we,
   input  wire logic [2:0] cfg_idx,
   input  wire logic [63:0] cfg_data,
   output pcn_pkg::work_type work
);
   logic [1:0] layout_ff;
   logic [2:0] count_ff;
   logic [12:0] height_ff, width_ff;
   logic [63:0] mean_ff, dev_ff;
   logic [1:0] chan_ff, chan_in;
   logic [23:0] pos_ff, pos_in;
   logic [2:0] act_count;
   logic [12:0] act_h, act_w;
   logic [24:0] size;
   logic pos_wrap;
   logic chan_wrap;
   logic signed [15:0] mean_sel;
   logic [15:0] dev_sel;
   logic signed [16:0] diff;
   logic [16:0] mag;

   always_comb begin
      act_count = (count_ff == 3'd0) ? 3'd1 : (count_ff > 3'd4) ? 3'd4 : count_ff;
      act_h = (height_ff == 13'd0) ? 13'd1 : (height_ff > 13'd4096) ? 13'd4096 : height_ff;
      act_w = (width_ff == 13'd0) ? 13'd1 : (width_ff > 13'd4096) ? 13'd4096 : width_ff;
      // a full 4096 by 4096 plane needs the 25th bit
      size = 25'(act_h) * 25'(act_w);
      mean_sel = mean_ff[16*chan_ff +: 16];
      dev_sel = dev_ff[16*chan_ff +: 16];
      diff = 17'(signed'(sample)) - 17'(mean_sel);
      mag = diff[16] ? 17'(-diff) : 17'(diff);
      chan_wrap = ({1'b0, chan_ff} + 3'd1) >= act_count;
      chan_in = chan_wrap ? 2'd0 : chan_ff + 2'd1;
      pos_in = pos_ff + 24'd1;
      pos_wrap = ({1'b0, pos_ff} + 25'd1) >= size;
      work.channel = chan_ff;
      work.zero_dev = (dev_sel == 16'd0);
      work.neg = diff[16];
      work.dividend = {mag, 13'd0} + 30'(dev_sel);
      work.divisor = {dev_sel, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         layout_ff <= 2'd0; count_ff <= 3'd3; height_ff <= 13'd1; width_ff <= 13'd1;
         mean_ff <= '0; dev_ff <= '0; chan_ff <= '0; pos_ff <= '0;
      end else if (cfg_we) begin
         case (cfg_idx)
            pcn_pkg::REG_LAYOUT: layout_ff <= cfg_data[1:0];
            pcn_pkg::REG_COUNT:  count_ff <= cfg_data[2:0];
            pcn_pkg::REG_HEIGHT: height_ff <= cfg_data[12:0];
            pcn_pkg::REG_WIDTH:  width_ff <= cfg_data[12:0];
            pcn_pkg::REG_MEAN:   mean_ff <= cfg_data;
            pcn_pkg::REG_DEV:    dev_ff <= cfg_data;
            default: ;
         endcase
         if (cfg_idx inside {pcn_pkg::REG_LAYOUT, pcn_pkg::REG_COUNT,
                             pcn_pkg::REG_HEIGHT, pcn_pkg::REG_WIDTH}) begin
            chan_ff <= '0;
            pos_ff <= '0;
         end
      end else if (take) begin
         if (!layout_ff[0] || pos_wrap) begin
            pos_ff <= '0;
            chan_ff <= chan_in;
         end else begin
            pos_ff <= pos_in;
         end
      end
   end
endmodule
`default_nettype wire

// ===== src/pcn_queue.sv =====
`default_nettype none
module pcn_queue (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  wire pcn_pkg::work_type din,
   output logic full,
   input  wire logic pop,
   output pcn_pkg::work_type dout,
   output logic empty
);
   pcn_pkg::work_type mem_ff [pcn_pkg::QUEUE_DEPTH];
   logic [pcn_pkg::QUEUE_AW:0] wr_ff, rd_ff;
   assign full = (wr_ff[pcn_pkg::QUEUE_AW] != rd_ff[pcn_pkg::QUEUE_AW]) &&
                 (wr_ff[pcn_pkg::QUEUE_AW-1:0] == rd_ff[pcn_pkg::QUEUE_AW-1:0]);
   assign empty = (wr_ff == rd_ff);
   assign dout = mem_ff[rd_ff[pcn_pkg::QUEUE_AW-1:0]];
   always_ff @(posedge clock) begin
      if (push && !full) mem_ff[wr_ff[pcn_pkg::QUEUE_AW-1:0]] <= din;
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0;
      end else begin
         if (push && !full) wr_ff <= wr_ff + 1'b1;
         if (pop && !empty) rd_ff <= rd_ff + 1'b1;
      end
   end
endmodule
`default_nettype wire

// ===== src/pcn_back.sv =====
`default_nettype none
module pcn_back (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic have_work,
   input  wire pcn_pkg::work_type work,
   output logic take_work,
   output logic rsp_empty,
   input  wire logic rsp_pop,
   output logic signed [23:0] rsp_normalized_value,
   output logic [1:0] rsp_channel_index,
   output logic [1:0] rsp_status
);
   // restoring divider, one quotient bit per cycle
   typedef enum logic [2:0] {IDLE = 3'b001, DIV = 3'b010, DONE = 3'b100} state_type;
   state_type state_ff;
   logic [4:0] step_ff;
   logic [29:0] rem_ff, quo_ff;
   logic [16:0] den_ff;
   logic neg_ff, zero_ff;
   logic [1:0] chan_ff;
   logic [30:0] trial;
   logic [29:0] q;
   logic sat;
   logic [23:0] res;

   assign take_work = (state_ff == IDLE) && have_work;
   assign rsp_empty = (state_ff != DONE);
   assign trial = {rem_ff, quo_ff[29]};

   always_comb begin
      q = quo_ff;
      sat = neg_ff ? (q > 30'd8388608) : (q > 30'd8388607);
      if (sat) q = neg_ff ? 30'd8388608 : 30'd8388607;
      res = neg_ff ? 24'(30'd0 - q) : q[23:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         case (state_ff)
            IDLE: if (have_work) begin
               chan_ff <= work.channel; neg_ff <= work.neg; zero_ff <= work.zero_dev;
               den_ff <= work.divisor; rem_ff <= '0; quo_ff <= work.dividend;
               step_ff <= '0;
               state_ff <= work.zero_dev ? DONE : DIV;
            end
            DIV: begin
               if (trial >= 31'(den_ff)) begin
                  rem_ff <= 30'(trial - 31'(den_ff));
                  quo_ff <= {quo_ff[28:0], 1'b1};
               end else begin
                  rem_ff <= trial[29:0];
                  quo_ff <= {quo_ff[28:0], 1'b0};
               end
               step_ff <= step_ff + 5'd1;
               if (step_ff == 5'd29) state_ff <= DONE;
            end
            DONE: if (rsp_pop) state_ff <= IDLE;
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign rsp_normalized_value = zero_ff ? 24'sd0 : res;
   assign rsp_channel_index = chan_ff;
   assign rsp_status = zero_ff ? pcn_pkg::ST_ZERO_DEV : sat ? pcn_pkg::ST_SAT : pcn_pkg::ST_OK;
endmodule
`default_nettype wire

// ===== src/per_channel_normalizer.sv =====
// Per-channel normalizer: each sample gives (x - mean[c]) / std[c] in Q12.12, rounded
// and saturated, with c taken from the layout counters. The front takes one sample per
// cycle into a four-entry queue while the queue is not full; the back runs a bit-serial
// divider and takes a new sample only after the previous result has been popped.
`default_nettype none
module per_channel_normalizer (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_push,
   output logic req_full,
   input  wire logic signed [15:0] req_sample_value,
   output logic rsp_empty,
   input  wire logic rsp_pop,
   output logic signed [23:0] rsp_normalized_value,
   output logic [1:0] rsp_channel_index,
   output logic [1:0] rsp_status,
   input  wire logic csr_we,
   input  wire logic [2:0] csr_index,
   input  wire logic [63:0] csr_data
);
   pcn_pkg::work_type fw, bw;
   logic q_empty, take;
   pcn_front u_front (.clock, .reset, .take(req_push && !req_full),
      .sample(req_sample_value), .cfg_we(csr_we), .cfg_idx(csr_index),
      .cfg_data(csr_data), .work(fw));
   pcn_queue u_queue (.clock, .reset, .push(req_push), .din(fw), .full(req_full),
      .pop(take), .dout(bw), .empty(q_empty));
   pcn_back u_back (.clock, .reset, .have_work(!q_empty), .work(bw), .take_work(take),
      .rsp_empty, .rsp_pop, .rsp_normalized_value, .rsp_channel_index, .rsp_status);
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
module tb_top;
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   wire  req_full;
   logic signed [15:0] req_sample_value = '0;
   wire  rsp_empty;
   logic rsp_pop = 1'b0;
   wire  signed [23:0] rsp_normalized_value;
   wire  [1:0] rsp_channel_index;
   wire  [1:0] rsp_status;
   logic csr_we = 1'b0;
   logic [2:0] csr_index = '0;
   logic [63:0] csr_data = '0;

   per_channel_normalizer uut (.*);

   always #5 clock = ~clock;

   typedef struct packed {
      logic signed [23:0] value;
      logic [1:0] channel;
      logic [1:0] status;
   } norm_result_type;

   // index with no register behind it
   localparam logic [2:0] REG_UNUSED = 3'd6;

   // shadow of the block's configuration and counters
   logic [1:0]  shadow_layout;
   logic [2:0]  shadow_count;
   logic [12:0] shadow_height;
   logic [12:0] shadow_width;
   logic [63:0] shadow_means;
   logic [63:0] shadow_devs;
   logic [1:0]  cur_channel;
   logic [23:0] cur_position;

   logic signed [15:0] directed_samples [12] = '{16'sh7fff, 16'sh8000, 16'sh0000,
      16'sh0001, 16'sh8000, 16'sh7fff, 16'sh0001, 16'shffff, 16'sh0100, 16'sh0003,
      16'shfffd, 16'sh7fff};

   logic signed [15:0] sample_queue[$];
   norm_result_type expected_results[$];
   int error_count = 0;
   int idle_cycles = 0;
   bit hold_sender = 1'b0;
   bit in_taken = 1'b0;
   int send_gap = 0;
   int pop_gap = 0;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic int clamp_dim(logic [12:0] v);
      if (v == 0) return 1;
      if (v > pcn_pkg::MAX_DIM) return pcn_pkg::MAX_DIM;
      return v;
   endfunction

   function automatic norm_result_type normalize(logic signed [15:0] x);
      norm_result_type r;
      logic signed [15:0] m;
      logic [15:0] s;
      int signed d;
      longint unsigned mag, q;
      bit neg;
      int lim;
      m = shadow_means[16*cur_channel +: 16];
      s = shadow_devs[16*cur_channel +: 16];
      d = int'(x) - int'(m);
      r.channel = cur_channel;
      r.status = pcn_pkg::ST_OK;
      r.value = '0;
      if (s == 0) begin
         r.status = pcn_pkg::ST_ZERO_DEV;
      end else begin
         neg = d < 0;
         mag = neg ? -d : d;
         q = (mag * 8192 + s) / (2 * s);
         lim = neg ? 8388608 : 8388607;
         if (q > lim) begin
            q = lim;
            r.status = pcn_pkg::ST_SAT;
         end
         r.value = neg ? 24'(-q) : 24'(q);
      end
      return r;
   endfunction

   function automatic void advance_counters();
      int n, size;
      n = shadow_count == 0 ? 1 :
          (shadow_count > pcn_pkg::MAX_CHANNELS ? pcn_pkg::MAX_CHANNELS : shadow_count);
      size = clamp_dim(shadow_height) * clamp_dim(shadow_width);
      if (!shadow_layout[0] || cur_position + 1 >= size) begin
         cur_position = 0;
         cur_channel = (cur_channel + 1 >= n) ? 2'd0 : 2'(cur_channel + 1);
      end else begin
         cur_position = cur_position + 1;
      end
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("error: %s got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (send_gap > 0) send_gap--;
         if (in_taken) send_gap = pick_gap();
         if (!req_push || in_taken) begin
            if (sample_queue.size() > 0 && send_gap == 0 && !hold_sender) begin
               req_push <= 1'b1;
               req_sample_value <= sample_queue[0];
            end else begin
               req_push <= 1'b0;
            end
         end
         if (pop_gap > 0) begin
            pop_gap--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
            if ($urandom_range(0, 3) == 0) pop_gap = pick_gap();
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (req_push && !req_full) begin
            expected_results.push_back(normalize(req_sample_value));
            advance_counters();
            void'(sample_queue.pop_front());
         end
         in_taken <= req_push && !req_full;
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (rsp_pop && !rsp_empty) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected transfer, value", rsp_normalized_value, 0);
            end else begin
               if (rsp_normalized_value !== expected_results[0].value)
                  report_mismatch("value", rsp_normalized_value, expected_results[0].value);
               if (rsp_channel_index !== expected_results[0].channel)
                  report_mismatch("channel", rsp_channel_index,
                                  expected_results[0].channel);
               if (rsp_status !== expected_results[0].status)
                  report_mismatch("status", rsp_status, expected_results[0].status);
               expected_results.pop_front();
            end
         end
         if (idle_cycles > 20000) begin
            $display("per_channel_normalizer: mismatch");
            $finish;
         end
      end
   end

   task automatic wait_drained();
      while (sample_queue.size() > 0 || req_push || expected_results.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [63:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         pcn_pkg::REG_LAYOUT: shadow_layout = val[1:0];
         pcn_pkg::REG_COUNT:  shadow_count = val[2:0];
         pcn_pkg::REG_HEIGHT: shadow_height = val[12:0];
         pcn_pkg::REG_WIDTH:  shadow_width = val[12:0];
         pcn_pkg::REG_MEAN:   shadow_means = val;
         pcn_pkg::REG_DEV:    shadow_devs = val;
         default: ;
      endcase
      if (idx < pcn_pkg::REG_MEAN) begin
         cur_channel = 0;
         cur_position = 0;
      end
   endtask

   function automatic logic [63:0] rand_means();
      return {$urandom(), $urandom()};
   endfunction

   function automatic logic [63:0] rand_devs();
      logic [63:0] v;
      v = {$urandom(), $urandom()};
      for (int c = 0; c < 4; c++) begin
         case ($urandom_range(0, 5))
            0: v[16*c +: 16] = 16'h0000;
            1: v[16*c +: 16] = $urandom_range(1, 8);
            2: v[16*c +: 16] = 16'h0100;
            3: v[16*c +: 16] = $urandom_range(0, 1023);
            default: ;
         endcase
      end
      return v;
   endfunction

   function automatic logic signed [15:0] rand_sample();
      case ($urandom_range(0, 7))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return 16'(int'($urandom_range(0, 1023)) - 512);
         default: return 16'($urandom());
      endcase
   endfunction

   initial begin
      shadow_layout = 0;
      shadow_count = 3;
      shadow_height = 1;
      shadow_width = 1;
      shadow_means = 0;
      shadow_devs = 0;
      cur_channel = 0;
      cur_position = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // zero deviation on every channel at reset
      for (int i = 0; i < 4; i++) sample_queue.push_back(rand_sample());
      wait_drained();

      // directed: extremes, exact, saturation, tie rounding, zero deviation
      write_reg(pcn_pkg::REG_MEAN, {16'sh8000, 16'sh7fff, 16'sh0000, 16'sh0100});
      write_reg(pcn_pkg::REG_DEV, {16'h0001, 16'hffff, 16'h0003, 16'h0000});
      write_reg(pcn_pkg::REG_COUNT, 4);
      foreach (directed_samples[i]) sample_queue.push_back(directed_samples[i]);
      wait_drained();
      // out-of-range shape values
      write_reg(pcn_pkg::REG_COUNT, 0);
      write_reg(pcn_pkg::REG_LAYOUT, 1);
      write_reg(pcn_pkg::REG_HEIGHT, 0);
      write_reg(pcn_pkg::REG_WIDTH, 8191);
      write_reg(pcn_pkg::REG_COUNT, 7);
      write_reg(REG_UNUSED, 64'hdead);
      for (int i = 0; i < 6; i++) sample_queue.push_back(rand_sample());
      wait_drained();

      // random phases over all layouts and shapes
      for (int ph = 0; ph < 20; ph++) begin
         write_reg(pcn_pkg::REG_LAYOUT, ph % 4);
         write_reg(pcn_pkg::REG_COUNT, ph == 3 ? 1 : $urandom_range(0, 7));
         write_reg(pcn_pkg::REG_HEIGHT, ph == 5 ? 4096 : $urandom_range(0, 4));
         write_reg(pcn_pkg::REG_WIDTH, ph == 5 ? 4096 : $urandom_range(0, 5));
         write_reg(pcn_pkg::REG_MEAN, ph == 7 ? 64'hffff_ffff_ffff_ffff : rand_means());
         write_reg(pcn_pkg::REG_DEV, ph == 7 ? 64'hffff_ffff_ffff_ffff : rand_devs());
         for (int i = 0; i < 75; i++) begin
            sample_queue.push_back(rand_sample());
            // let the results drain once mid-phase
            if (ph == 2 && i == 40) begin
               while (sample_queue.size() > 0 || req_push) @(posedge clock);
               hold_sender = 1'b1;
               while (expected_results.size() > 0) @(posedge clock);
               hold_sender = 1'b0;
            end
         end
         wait_drained();
      end

      if (error_count == 0) $display("per_channel_normalizer: match");
      else $display("per_channel_normalizer: mismatch");
      $finish;
   end
endmodule
